### src/assert_macros.svh
// Assertion helpers shared by the window generator RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define CHECK_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/cswg_pkg.sv
// Types and constants of the cosine-sum window generator.
// No dependencies; used by every module in src.
package cswg_pkg;

    localparam int MAX_LENGTH     = 4096;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PH_BITS        = 24;
    localparam int IDX_W          = 12;
    localparam int LEN_W          = 13;
    localparam int COEF_W         = 17;

    // Divider: one quotient bit per cell, quotient bits 24 down to 0
    localparam int DIV_CELLS = PH_BITS + 1;
    localparam int REM_W     = IDX_W + 1;

    localparam int HORNER_STEPS = 4;
    localparam int HORNER_LAT   = 3;
    localparam int COS_LAT      = 5 + HORNER_STEPS * HORNER_LAT;
    localparam int PIPE_DEPTH   = DIV_CELLS + 1 + COS_LAT + 3;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

    localparam int COS_DIV [HORNER_STEPS] = '{56, 30, 12, 2};
    localparam int SIN_DIV [HORNER_STEPS] = '{72, 42, 20, 6};

    // Q30 weights
    localparam logic [29:0] W_HAM0 = 30'd579820585;
    localparam logic [29:0] W_HAM1 = 30'd493921239;
    localparam logic [29:0] W_HANN = 30'd536870912;
    localparam logic [29:0] W_BLK0 = 30'd458048598;
    localparam logic [29:0] W_BLK1 = 30'd533178314;
    localparam logic [29:0] W_BLK2 = 30'd82514912;
    localparam logic [29:0] W_BH0  = 30'd385204879;
    localparam logic [29:0] W_BH1  = 30'd524297395;
    localparam logic [29:0] W_BH2  = 30'd151698245;
    localparam logic [29:0] W_BH3  = 30'd12541305;

    typedef enum logic [2:0] {
        WIN_RECT     = 3'd0,
        WIN_HAMMING  = 3'd1,
        WIN_HANN     = 3'd2,
        WIN_BLACKMAN = 3'd3,
        WIN_BHARRIS  = 3'd4
    } win_kind_t;

    typedef enum logic {
        REG_WINDOW_TYPE   = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_CELLS-1:0] quo;
    } div_state_t;

    typedef struct packed {
        logic [29:0] x2;
        logic [30:0] t;
    } poly_state_t;

    typedef struct packed {
        logic [1:0]  quad;
        logic        fold;
        logic [29:0] x;
    } fold_side_t;

endpackage

### src/cswg_div_cell.sv
// One cell of the phase divider: resolves one quotient bit per cycle while en is high.
// Depends on cswg_pkg.
module cswg_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [cswg_pkg::IDX_W-1:0] divisor,
    input  cswg_pkg::div_state_t       din,
    output cswg_pkg::div_state_t       dout
);
    import cswg_pkg::*;

    div_state_t       state_reg;
    div_state_t       state_next;
    logic [REM_W-1:0] shifted;
    logic             ge;

    always_comb begin
        shifted = FIRST ? din.rem : {din.rem[REM_W-2:0], 1'b0};
        ge      = shifted >= {1'b0, divisor};
        state_next.rem = ge ? (shifted - {1'b0, divisor}) : shifted;
        state_next.quo = {din.quo[DIV_CELLS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

### src/cswg_horner_cell.sv
// One Horner step t' = 1 - floor(floor(x2*t/2^30)/DIV), three register stages.
// Depends on cswg_pkg.
module cswg_horner_cell #(
    parameter int DIV = 2
) (
    input  logic                  aclk,
    input  logic                  en,
    input  cswg_pkg::poly_state_t din,
    output cswg_pkg::poly_state_t dout
);
    import cswg_pkg::*;

    // exact for dividends up to 2^30 and divisors below 128
    localparam logic [36:0] RECIP = 37'(((65'd1 << 37) + 65'(DIV) - 65'd1) / 65'(DIV));

    logic [60:0] mul_full;
    logic [30:0] m_reg;
    logic [29:0] x2a_reg;
    logic [48:0] plo_reg;
    logic [49:0] phi_reg;
    logic [29:0] x2b_reg;
    logic [67:0] quo_full;
    logic [30:0] quo;
    poly_state_t out_reg;

    assign mul_full = 61'(din.x2) * 61'(din.t);
    assign quo_full = {phi_reg, 18'b0} + 68'(plo_reg);
    assign quo      = quo_full[67:37];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg      <= mul_full[60:30];
            x2a_reg    <= din.x2;
            // split the reciprocal product into two partial products
            plo_reg    <= 49'(m_reg) * 49'(RECIP[17:0]);
            phi_reg    <= 50'(m_reg) * 50'(RECIP[36:18]);
            x2b_reg    <= x2a_reg;
            out_reg.x2 <= x2b_reg;
            out_reg.t  <= Q30_ONE - quo;
        end
    end

    assign dout = out_reg;

endmodule

### src/cswg_cos_unit.sv
// Cosine of a 24-bit turn fraction as signed Q30: octant folding, angle
// scaling, then chains of Horner cells for cos and sin. Depends on cswg_pkg.
module cswg_cos_unit (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [cswg_pkg::PH_BITS-1:0] turn,
    output logic signed [31:0]           cos_val
);
    import cswg_pkg::*;

    localparam int SIDE_LEN = HORNER_STEPS * HORNER_LAT;

    logic [1:0]         quad1_reg;
    logic               fold1_reg;
    logic [21:0]        rr1_reg;
    logic [21:0]        r_frac;
    logic               fold_now;
    logic [22:0]        r_mirror;
    logic [55:0]        ang_prod;
    fold_side_t         side2_reg;
    logic [59:0]        sq_full;
    poly_state_t        chain_in_reg;
    poly_state_t        cos_chain [0:HORNER_STEPS];
    poly_state_t        sin_chain [0:HORNER_STEPS];
    fold_side_t         side_reg [0:SIDE_LEN];
    logic [60:0]        sin_full;
    logic [30:0]        sin_reg;
    logic [30:0]        cosp_reg;
    logic [1:0]         quad16_reg;
    logic               fold16_reg;
    logic signed [31:0] c_val;
    logic signed [31:0] s_val;
    logic signed [31:0] out_next;
    logic signed [31:0] out_reg;

    assign r_frac   = turn[21:0];
    assign fold_now = r_frac > 22'h20_0000;
    assign r_mirror = 23'h40_0000 - {1'b0, r_frac};
    assign ang_prod = 56'(rr1_reg) * 56'(TWO_PI_Q30);
    assign sq_full  = 60'(side2_reg.x) * 60'(side2_reg.x);

    always_ff @(posedge aclk) begin
        if (en) begin
            quad1_reg          <= turn[23:22];
            fold1_reg          <= fold_now;
            rr1_reg            <= fold_now ? r_mirror[21:0] : r_frac;
            side2_reg.quad     <= quad1_reg;
            side2_reg.fold     <= fold1_reg;
            side2_reg.x        <= ang_prod[53:24];
            chain_in_reg.x2    <= sq_full[59:30];
            chain_in_reg.t     <= Q30_ONE;
            side_reg[0]        <= side2_reg;
            for (int k = 1; k <= SIDE_LEN; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign cos_chain[0] = chain_in_reg;
    assign sin_chain[0] = chain_in_reg;

    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
        cswg_horner_cell #(.DIV(COS_DIV[g])) u_cos (
            .aclk (aclk),
            .en   (en),
            .din  (cos_chain[g]),
            .dout (cos_chain[g+1])
        );
        cswg_horner_cell #(.DIV(SIN_DIV[g])) u_sin (
            .aclk (aclk),
            .en   (en),
            .din  (sin_chain[g]),
            .dout (sin_chain[g+1])
        );
    end

    assign sin_full = 61'(side_reg[SIDE_LEN].x) * 61'(sin_chain[HORNER_STEPS].t);

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg    <= sin_full[60:30];
            cosp_reg   <= cos_chain[HORNER_STEPS].t;
            quad16_reg <= side_reg[SIDE_LEN].quad;
            fold16_reg <= side_reg[SIDE_LEN].fold;
            out_reg    <= out_next;
        end
    end

    // swap cos and sin past the octant, then apply the quadrant sign
    always_comb begin
        c_val = fold16_reg ? $signed({1'b0, sin_reg}) : $signed({1'b0, cosp_reg});
        s_val = fold16_reg ? $signed({1'b0, cosp_reg}) : $signed({1'b0, sin_reg});
        case (quad16_reg)
            2'd0:    out_next = c_val;
            2'd1:    out_next = -s_val;
            2'd2:    out_next = -c_val;
            default: out_next = s_val;
        endcase
    end

    assign cos_val = out_reg;

endmodule

### src/cosine_sum_window_generator_unit.sv
// Cosine-sum window generator: one sample index per beat in, one window
// coefficient per beat out (rectangle, Hamming, Hann, Blackman, Blackman-Harris).
// The unit takes one index every cycle unless the output stalls; each result
// passes 46 register stages: 25 cells of a bit-per-cell phase divider, one
// phase stage, 17 stages of each cosine unit and three stages of weighted sum
// and rounding. A stall on the output holds the whole pipeline.
// Depends on cswg_pkg, the cells and the cosine unit, and on assert_macros.svh.
`include "assert_macros.svh"

module cosine_sum_window_generator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [cswg_pkg::LEN_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [11:0] sample_index
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [16:0] coefficient
    output logic                          m_tuser    // [0] in_range
);
    import cswg_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    logic [2:0]         window_type_reg;
    logic [LEN_W-1:0]   window_length_reg;
    logic [LEN_W-1:0]   n_eff;
    logic [IDX_W-1:0]   divisor;
    logic               adv;
    logic               vld_reg [0:LAST];
    logic               rng_reg [0:LAST];
    logic               zph_reg [0:DIV_CELLS-1];
    div_state_t         div_chain [0:DIV_CELLS];
    logic [DIV_CELLS-1:0] phase;
    logic [PH_BITS-1:0] t1_reg, t2_reg, t3_reg;
    logic signed [31:0] c1, c2, c3;
    logic [29:0]        w0, w1, w2, w3;
    logic               rect_now;
    logic signed [63:0] base_reg, p1_reg, p2_reg, p3_reg;
    logic               rect1_reg, rect2_reg;
    logic signed [63:0] a_reg, b_reg;
    logic signed [63:0] sum_val;
    logic [60:0]        clamped;
    logic [61:0]        rounded;
    logic [COEF_W-1:0]  coef_next;
    logic [COEF_W-1:0]  coef_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_type_reg   <= WIN_RECT;
            window_length_reg <= 13'd1024;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_WINDOW_TYPE:   window_type_reg   <= cfg_wdata[2:0];
                REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                default:           window_type_reg   <= window_type_reg;
            endcase
        end
    end

    assign n_eff    = (window_length_reg > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                               : window_length_reg;
    assign divisor  = IDX_W'(n_eff - 13'd1);
    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;

    // valid and flag delay lines
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= LAST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rng_reg[0] <= {1'b0, s_tdata[IDX_W-1:0]} < n_eff;
            zph_reg[0] <= n_eff <= 13'd1;
            for (int k = 1; k <= LAST; k++) begin
                rng_reg[k] <= rng_reg[k-1];
            end
            for (int k = 1; k < DIV_CELLS; k++) begin
                zph_reg[k] <= zph_reg[k-1];
            end
        end
    end

    // phase = floor(i * 2^24 / (N-1))
    assign div_chain[0].rem = {1'b0, s_tdata[IDX_W-1:0]};
    assign div_chain[0].quo = '0;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        cswg_div_cell #(.FIRST(g == 0)) u_cell (
            .aclk    (aclk),
            .en      (adv),
            .divisor (divisor),
            .din     (div_chain[g]),
            .dout    (div_chain[g+1])
        );
    end

    assign phase = zph_reg[DIV_CELLS-1] ? '0 : div_chain[DIV_CELLS].quo;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg <= phase[PH_BITS-1:0];
            t2_reg <= {phase[PH_BITS-2:0], 1'b0};
            t3_reg <= phase[PH_BITS-1:0] + {phase[PH_BITS-2:0], 1'b0};
        end
    end

    cswg_cos_unit u_cos1 (.aclk(aclk), .en(adv), .turn(t1_reg), .cos_val(c1));
    cswg_cos_unit u_cos2 (.aclk(aclk), .en(adv), .turn(t2_reg), .cos_val(c2));
    cswg_cos_unit u_cos3 (.aclk(aclk), .en(adv), .turn(t3_reg), .cos_val(c3));

    always_comb begin
        w0       = '0;
        w1       = '0;
        w2       = '0;
        w3       = '0;
        rect_now = 1'b0;
        unique case (win_kind_t'(window_type_reg))
            WIN_HAMMING: begin
                w0 = W_HAM0;
                w1 = W_HAM1;
            end
            WIN_HANN: begin
                w0 = W_HANN;
                w1 = W_HANN;
            end
            WIN_BLACKMAN: begin
                w0 = W_BLK0;
                w1 = W_BLK1;
                w2 = W_BLK2;
            end
            WIN_BHARRIS: begin
                w0 = W_BH0;
                w1 = W_BH1;
                w2 = W_BH2;
                w3 = W_BH3;
            end
            default: rect_now = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            base_reg  <= $signed({4'b0, w0, 30'b0});
            p1_reg    <= $signed({34'b0, w1}) * 64'(c1);
            p2_reg    <= $signed({34'b0, w2}) * 64'(c2);
            p3_reg    <= $signed({34'b0, w3}) * 64'(c3);
            rect1_reg <= rect_now;
            a_reg     <= base_reg - p1_reg;
            b_reg     <= p2_reg - p3_reg;
            rect2_reg <= rect1_reg;
            coef_reg  <= coef_next;
        end
    end

    // clamp to [0, 1.0] in Q60, round half up to 16 fraction bits
    always_comb begin
        sum_val = rect2_reg ? 64'sh1000_0000_0000_0000 : (a_reg + b_reg);
        if (sum_val < 0) begin
            clamped = '0;
        end else if (sum_val > 64'sh1000_0000_0000_0000) begin
            clamped = 61'h1000_0000_0000_0000;
        end else begin
            clamped = sum_val[60:0];
        end
        rounded   = (62'(clamped) + (62'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
        coef_next = rng_reg[LAST-1] ? rounded[COEF_W-1:0] : '0;
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {7'b0, coef_reg};
    assign m_tuser  = rng_reg[LAST];

    `CHECK_AT(a_out_of_range_zero, m_tvalid && !m_tuser |-> coef_reg == '0, "out-of-range beat with nonzero coefficient")
    `CHECK_AT(a_coef_bound, m_tvalid |-> coef_reg <= COEF_W'(1 << COEF_FRAC_BITS), "coefficient above 1.0")
    `CHECK_AT(a_rect_unity, m_tvalid && m_tuser && window_type_reg == WIN_RECT |-> coef_reg == COEF_W'(1 << COEF_FRAC_BITS), "rectangle window not 1.0")
    `CHECK_ALWAYS(a_ready_when_free, !m_tvalid || m_tready |-> s_tready, "input held with free output")
    `CHECK_AT(a_stall_blocks_input, m_tvalid && !m_tready |-> !s_tready, "input taken during stall")

endmodule

### tb/sv/testbench.sv
// Self-checking bench for cosine_sum_window_generator_unit: drives sample
// indices over the stream port and compares every coefficient with a local
// bit-exact model. Depends on cswg_pkg and the RTL of the unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cswg_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  PIPE_LAT    = 46;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        bit [16:0] coef;
        bit        in_range;
    } window_out_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_addr;
    logic [LEN_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [11:0] sample_index
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // [16:0] coefficient
    logic              m_tuser;   // [0] in_range

    window_out_t coef_queue[$];
    bit [2:0]    win_type_shadow;
    bit [12:0]   win_len_shadow;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          fail_count;
    longint      cycle_count;

    cosine_sum_window_generator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #HALF_PERIOD;
        aclk = 1'b0;
        #HALF_PERIOD;
    end

    // Horner chain shared by cosine and sine; sine scales by x at the end.
    function automatic bit [63:0] taylor_q30(bit [63:0] x, bit is_sin);
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] dv;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int s = 0; s < HORNER_STEPS; s++) begin
            dv = is_sin ? 64'(SIN_DIV[s]) : 64'(COS_DIV[s]);
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / dv;
        end
        return is_sin ? ((x * t) >> 30) : t;
    endfunction

    function automatic longint cos_of_turn(bit [23:0] t);
        bit [1:0]  quad;
        bit [63:0] r;
        bit [63:0] x;
        longint    c;
        longint    s;
        quad = t[23:22];
        r    = 64'(t[21:0]);
        if (r <= (64'd1 << 21)) begin
            x = (r * 64'(TWO_PI_Q30)) >> 24;
            c = longint'(taylor_q30(x, 1'b0));
            s = longint'(taylor_q30(x, 1'b1));
        end else begin
            // fold onto the first octant
            x = (((64'd1 << 22) - r) * 64'(TWO_PI_Q30)) >> 24;
            c = longint'(taylor_q30(x, 1'b1));
            s = longint'(taylor_q30(x, 1'b0));
        end
        case (quad)
            2'd0: return c;
            2'd1: return -s;
            2'd2: return -c;
            default: return s;
        endcase
    endfunction

    function automatic window_out_t window_coef(bit [11:0] idx);
        window_out_t res;
        bit [63:0]   n;
        bit [63:0]   p;
        longint      c1, c2, c3, sum, one60;
        bit [63:0]   v;
        n = (win_len_shadow > MAX_LENGTH) ? 64'(MAX_LENGTH) : 64'(win_len_shadow);
        if (64'(idx) >= n) begin
            res.coef = '0;
            res.in_range = 1'b0;
            return res;
        end
        p  = (n > 1) ? ((64'(idx) << 24) / (n - 1)) : 64'd0;
        c1 = cos_of_turn(p[23:0]);
        c2 = cos_of_turn(24'(2 * p));
        c3 = cos_of_turn(24'(3 * p));
        one60 = longint'(1) << 60;
        case (win_type_shadow)
            WIN_HAMMING:  sum = longint'(W_HAM0) * (longint'(1) << 30) - longint'(W_HAM1) * c1;
            WIN_HANN:     sum = longint'(W_HANN) * (longint'(1) << 30) - longint'(W_HANN) * c1;
            WIN_BLACKMAN: sum = longint'(W_BLK0) * (longint'(1) << 30) - longint'(W_BLK1) * c1
                              + longint'(W_BLK2) * c2;
            WIN_BHARRIS:  sum = longint'(W_BH0) * (longint'(1) << 30) - longint'(W_BH1) * c1
                              + longint'(W_BH2) * c2 - longint'(W_BH3) * c3;
            default:      sum = one60;
        endcase
        if (sum < 0) sum = 0;
        if (sum > one60) sum = one60;
        v = (64'(sum) + (64'd1 << 43)) >> 44;
        if (v > 64'd65536) v = 64'd65536;
        res.coef = v[16:0];
        res.in_range = 1'b1;
        return res;
    endfunction

    // Leave the write enable high; the caller drops it after the last write.
    task automatic write_reg(cfg_reg_t addr, bit [12:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        if (addr == REG_WINDOW_TYPE) win_type_shadow = val[2:0];
        else win_len_shadow = val;
    endtask

    // Hold the sender until the pipe has emptied.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (coef_queue.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 4) @(negedge aclk);
    endtask

    task automatic configure(bit [2:0] kind, bit [12:0] len);
        drain_results();
        write_reg(REG_WINDOW_TYPE, 13'(kind));
        write_reg(REG_WINDOW_LENGTH, len);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_index(bit [11:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, idx};
        do @(posedge aclk); while (!s_tready);
        coef_queue.push_back(window_coef(idx));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        window_out_t exp_out;
        if (aresetn && m_tvalid && m_tready) begin
            if (coef_queue.size() == 0) begin
                $display("%0t: unexpected beat coef=%0d in_range=%0b",
                         $time, m_tdata[16:0], m_tuser);
                fail_count++;
            end else begin
                exp_out = coef_queue.pop_front();
                if (m_tdata[16:0] !== exp_out.coef) begin
                    $display("%0t: coefficient expected %0d actual %0d",
                             $time, exp_out.coef, m_tdata[16:0]);
                    fail_count++;
                end
                if (m_tuser !== exp_out.in_range) begin
                    $display("%0t: in_range expected %0b actual %0b",
                             $time, exp_out.in_range, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        // rectangle over 1024 points out of reset
        send_index(12'd0);
        send_index(12'd1023);
        send_index(12'd1024);
        send_index(12'd4095);
    endtask

    task automatic test_window_kinds();
        for (int k = 0; k < 8; k++) begin
            configure(3'(k), 13'd64);
            send_index(12'd0);
            send_index(12'd16);
            send_index(12'd32);
            send_index(12'd63);
        end
    endtask

    task automatic test_odd_lengths();
        configure(WIN_HANN, 13'd0);
        send_index(12'd0);
        configure(WIN_BHARRIS, 13'd1);
        send_index(12'd0);
        send_index(12'd1);
        configure(WIN_BLACKMAN, 13'd2);
        send_index(12'd1);
        configure(WIN_HAMMING, 13'd8191);
        send_index(12'd4095);
        send_index(12'd2048);
    endtask

    task automatic test_random_windows(int tx_pct, int rx_pct, int count);
        bit [12:0] len;
        bit [11:0] idx;
        int sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0: len = 13'd4096;
                1: len = 13'($urandom_range(2, 16));
                2: len = 13'($urandom_range(4097, 8191));
                default: len = 13'($urandom_range(2, 4096));
            endcase
            configure(($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7)),
                      len);
            for (int j = 0; j < 40 && sent < count; j++) begin
                if ($urandom_range(9) < 8) idx = 12'($urandom_range(4095) % 4096);
                else idx = 12'($urandom);
                if ($urandom_range(3) != 0 && len > 1)
                    idx = 12'($urandom_range((len > 4096 ? 4096 : len) - 1));
                send_index(idx);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_WINDOW_TYPE;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fail_count  = 0;
        cycle_count = 0;
        win_type_shadow = WIN_RECT;
        win_len_shadow  = 13'd1024;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        test_reset_defaults();
        test_window_kinds();
        test_odd_lengths();
        test_random_windows(15, 85, 200);
        test_random_windows(85, 15, 200);
        test_random_windows(0, 0, 200);
        drain_results();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### files.f
+incdir+src
src/cswg_pkg.sv
src/cswg_div_cell.sv
src/cswg_horner_cell.sv
src/cswg_cos_unit.sv
src/cosine_sum_window_generator_unit.sv
tb/sv/testbench.sv
